[design/apc_pkg.sv]
// ----------------------------------------------------------------------------
// apc_pkg
// Shared types and constants for the arm64 pc-relative codec: beat payload
// structs, instruction kind codes and the opcode match patterns.
// ----------------------------------------------------------------------------
package apc_pkg;

   // instruction kind codes
   localparam logic [3:0] KIND_OTHER = 4'd0;
   localparam logic [3:0] KIND_B     = 4'd1;
   localparam logic [3:0] KIND_BL    = 4'd2;
   localparam logic [3:0] KIND_BCOND = 4'd3;
   localparam logic [3:0] KIND_CB    = 4'd4;
   localparam logic [3:0] KIND_TB    = 4'd5;
   localparam logic [3:0] KIND_ADR   = 4'd6;
   localparam logic [3:0] KIND_ADRP  = 4'd7;
   localparam logic [3:0] KIND_LIT   = 4'd8;

   // action codes
   localparam logic ACT_DECODE = 1'b0;
   localparam logic ACT_ENCODE = 1'b1;

   // opcode masks and match values
   localparam logic [31:0] MASK_B      = 32'h7c000000;
   localparam logic [31:0] MATCH_B     = 32'h14000000;
   localparam logic [31:0] MASK_BCOND  = 32'hff000000;
   localparam logic [31:0] MATCH_BCOND = 32'h54000000;
   localparam logic [31:0] MASK_CBTB   = 32'h7e000000;
   localparam logic [31:0] MATCH_CB    = 32'h34000000;
   localparam logic [31:0] MATCH_TB    = 32'h36000000;
   localparam logic [31:0] MASK_ADR    = 32'h1f000000;
   localparam logic [31:0] MATCH_ADR   = 32'h10000000;
   localparam logic [31:0] MASK_LIT    = 32'h3b000000;
   localparam logic [31:0] MATCH_LIT   = 32'h18000000;

   typedef struct packed {
      logic        action;
      logic [31:0] instruction_word;
      logic [63:0] pc_address;
      logic [63:0] target_address;
   } req_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [63:0] decoded_target;
      logic [31:0] encoded_word;
      logic        ok;
   } rsp_type;

endpackage

[design/apc_if.sv]
// ----------------------------------------------------------------------------
// apc_if
// Valid/ready channels of the codec: request beats in, result beats out.
// ----------------------------------------------------------------------------
interface apc_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [31:0] instruction_word;
   logic [63:0] pc_address;
   logic [63:0] target_address;

   modport source (output valid, action, instruction_word, pc_address, target_address,
                   input ready);
   modport sink   (input valid, action, instruction_word, pc_address, target_address,
                   output ready);
endinterface

interface apc_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  kind;
   logic [63:0] decoded_target;
   logic [31:0] encoded_word;
   logic        ok;

   modport source (output valid, kind, decoded_target, encoded_word, ok, input ready);
   modport sink   (input valid, kind, decoded_target, encoded_word, ok, output ready);
endinterface

[design/apc_core.sv]
// ----------------------------------------------------------------------------
// apc_core
// Combinational classify, decode and re-encode of one instruction beat.
// One 64-bit adder for the decoded target, one 65-bit subtractor for the
// encode distance, then sign-range checks on the distance.
// ----------------------------------------------------------------------------
module apc_core (
   input  apc_pkg::req_type req_data,
   output apc_pkg::rsp_type rsp_data
);
   import apc_pkg::*;

   logic [31:0] w;
   logic [3:0]  kind;
   logic        is_adrp;
   logic [63:0] pc_base;
   logic [63:0] tgt_base;
   logic [63:0] offset;
   logic [63:0] target;
   logic [64:0] distance;
   logic        aligned;
   logic        fits;
   logic [31:0] enc;

   assign w = req_data.instruction_word;

   // classify, first match wins
   always_comb begin
      priority if ((w & MASK_B) == MATCH_B) begin
         kind = w[31] ? KIND_BL : KIND_B;
      end else if ((w & MASK_BCOND) == MATCH_BCOND) begin
         kind = KIND_BCOND;
      end else if ((w & MASK_CBTB) == MATCH_CB) begin
         kind = KIND_CB;
      end else if ((w & MASK_CBTB) == MATCH_TB) begin
         kind = KIND_TB;
      end else if ((w & MASK_ADR) == MATCH_ADR) begin
         kind = w[31] ? KIND_ADRP : KIND_ADR;
      end else if ((w & MASK_LIT) == MATCH_LIT) begin
         kind = KIND_LIT;
      end else begin
         kind = KIND_OTHER;
      end
   end

   // adrp works on 4 KiB page bases
   assign is_adrp  = (kind == KIND_ADRP);
   assign pc_base  = is_adrp ? {req_data.pc_address[63:12], 12'h000} : req_data.pc_address;
   assign tgt_base = is_adrp ? {req_data.target_address[63:12], 12'h000}
                             : req_data.target_address;

   // sign-extended byte offset of the current immediate
   always_comb begin
      unique case (kind)
         KIND_B, KIND_BL:             offset = {{36{w[25]}}, w[25:0], 2'b00};
         KIND_BCOND, KIND_CB, KIND_LIT: offset = {{43{w[23]}}, w[23:5], 2'b00};
         KIND_TB:                     offset = {{48{w[18]}}, w[18:5], 2'b00};
         KIND_ADR:                    offset = {{43{w[23]}}, w[23:5], w[30:29]};
         KIND_ADRP:                   offset = {{31{w[23]}}, w[23:5], w[30:29], 12'h000};
         default:                     offset = 64'd0;
      endcase
   end

   assign target = pc_base + offset;

   // exact signed distance, one bit wider than the addresses
   assign distance = {1'b0, tgt_base} - {1'b0, pc_base};
   assign aligned  = (distance[1:0] == 2'b00);

   // field range check: all bits above the field equal its sign bit
   always_comb begin
      unique case (kind)
         KIND_B, KIND_BL: begin
            fits = aligned && ((&distance[64:27]) || !(|distance[64:27]));
            enc  = {w[31:26], distance[27:2]};
         end
         KIND_BCOND, KIND_CB, KIND_LIT: begin
            fits = aligned && ((&distance[64:20]) || !(|distance[64:20]));
            enc  = {w[31:24], distance[20:2], w[4:0]};
         end
         KIND_TB: begin
            fits = aligned && ((&distance[64:15]) || !(|distance[64:15]));
            enc  = {w[31:19], distance[15:2], w[4:0]};
         end
         KIND_ADR: begin
            fits = (&distance[64:20]) || !(|distance[64:20]);
            enc  = {w[31], distance[1:0], w[28:24], distance[20:2], w[4:0]};
         end
         KIND_ADRP: begin
            fits = (&distance[64:32]) || !(|distance[64:32]);
            enc  = {w[31], distance[13:12], w[28:24], distance[32:14], w[4:0]};
         end
         default: begin
            fits = 1'b0;
            enc  = 32'd0;
         end
      endcase
   end

   // result beat
   always_comb begin
      rsp_data.kind = kind;
      if (req_data.action == ACT_DECODE) begin
         rsp_data.decoded_target = (kind != KIND_OTHER) ? target : 64'd0;
         rsp_data.encoded_word   = 32'd0;
         rsp_data.ok             = (kind != KIND_OTHER);
      end else begin
         rsp_data.decoded_target = 64'd0;
         rsp_data.encoded_word   = fits ? enc : 32'd0;
         rsp_data.ok             = fits;
      end
   end

endmodule

[design/arm64_pc_relative_codec.sv]
// ----------------------------------------------------------------------------
// arm64_pc_relative_codec
// Classifies an arm64 instruction word and decodes or re-encodes its
// pc-relative immediate.
//
// Each request beat is captured in an input register, classified, decoded
// or re-encoded in one pass of logic, and lands in a result register,
// from which the result beat is offered; the block takes one beat per
// cycle when the result side keeps up. The single 64-bit target adder and
// 65-bit distance subtractor between the two registers set the clock
// period. A waiting result holds the input register, which can still
// take one beat while it is empty.
// ----------------------------------------------------------------------------
module arm64_pc_relative_codec (
   input  logic      clock,
   input  logic      reset,
   apc_req_if.sink   req_if,
   apc_rsp_if.source rsp_if
);
   import apc_pkg::*;

   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_data_ff;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type core_rsp;
   logic    rsp_stage_ready;
   logic    in_stage_ready;
   logic    req_beat;

   // backpressure chain
   assign rsp_stage_ready = !rsp_valid_ff || rsp_if.ready;
   assign in_stage_ready  = !in_valid_ff || rsp_stage_ready;
   assign req_if.ready    = in_stage_ready;
   assign req_beat        = req_if.valid && in_stage_ready;

   // input register
   assign in_valid_in = req_beat ? 1'b1 : (rsp_stage_ready ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_data_ff.action           <= req_if.action;
         in_data_ff.instruction_word <= req_if.instruction_word;
         in_data_ff.pc_address       <= req_if.pc_address;
         in_data_ff.target_address   <= req_if.target_address;
      end
   end

   apc_core u_core (
      .req_data (in_data_ff),
      .rsp_data (core_rsp)
   );

   // result register
   assign rsp_valid_in = rsp_stage_ready ? in_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_stage_ready && in_valid_ff) begin
         rsp_data_ff <= core_rsp;
      end
   end

   // result beat
   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.kind           = rsp_data_ff.kind;
   assign rsp_if.decoded_target = rsp_data_ff.decoded_target;
   assign rsp_if.encoded_word   = rsp_data_ff.encoded_word;
   assign rsp_if.ok             = rsp_data_ff.ok;

   // accepted beat always lands in the input register
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> in_valid_ff)
      else $error("accepted request beat lost");

   // a waiting result is never overwritten
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_if.ready |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("stalled result changed");

   // decode and encode outputs are exclusive
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.decoded_target != 64'd0)
      |-> rsp_data_ff.encoded_word == 32'd0)
      else $error("both decode and encode fields set");

   // unclassified words never succeed
   a_other_fails: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.kind == KIND_OTHER) |-> !rsp_data_ff.ok)
      else $error("ok set on unclassified word");

   // nonzero encoding implies success
   a_enc_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.encoded_word != 32'd0) |-> rsp_data_ff.ok)
      else $error("encoded word without ok");

endmodule
